@@ hdl/wstd_pkg.sv @@
// Shared types and codes for the work-stealing task deque.
package wstd_pkg;

    localparam int MODE_W      = 2;
    localparam int FIELD_W     = 32;
    localparam int MAXC_W      = 6;
    localparam int COUNT_OUT_W = 7;
    localparam int SUM_W       = 38;
    localparam int MAX_RESULTS = 32;

    // Operation codes as they arrive on the mode port.
    typedef enum logic [MODE_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_STEAL = 2'd2,
        OP_SHARE = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_CHEAP = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SHARE
    } back_state_t;

    // One queued command, as passed from the front end to the back end.
    typedef struct packed {
        op_t                op;
        logic [FIELD_W-1:0] task_id;
        logic [FIELD_W-1:0] task_cost;
        logic [MAXC_W-1:0]  batch_limit;
        logic [FIELD_W-1:0] min_cost;
        logic               check_cost;
    } cmd_t;

endpackage

@@ hdl/wstd_front.sv @@
// Front end: accepts items, classifies the mode and buffers them in a two-entry queue.
module wstd_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [1:0]                 mode,
    input  logic [31:0]                task_id,
    input  logic [31:0]                task_cost,
    input  logic [5:0]                 batch_limit,
    input  logic [31:0]                min_cost,
    input  logic                       check_cost,
    output logic                       busy,
    output logic                       q_valid,
    output wstd_pkg::cmd_t             q_cmd,
    input  logic                       q_pop
);
    import wstd_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.task_id     = task_id;
        cmd_in.task_cost   = task_cost;
        cmd_in.batch_limit = batch_limit;
        cmd_in.min_cost    = min_cost;
        cmd_in.check_cost  = check_cost;
        // all four codes are defined
        cmd_in.op          = op_t'(mode);
    end

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ hdl/wstd_back.sv @@
// Back end: task store, occupancy and cost bookkeeping, operation sequencer and result registers.
module wstd_back
#(
    parameter int DEPTH      = 64,
    parameter int ID_WIDTH   = 32,
    parameter int COST_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  wstd_pkg::cmd_t       q_cmd,
    output logic                 q_pop,
    output logic                 result_valid,
    output logic                 found,
    output logic [31:0]          out_task_id,
    output logic [31:0]          out_task_cost,
    output logic [1:0]           status,
    output logic [6:0]           queue_count,
    output logic [37:0]          cost_total,
    output logic                 last
);
    import wstd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ID_WIDTH + COST_WIDTH;
    localparam int TW = CW + MAXC_W;

    // task store (memory) and its read port
    logic [EW-1:0]         store_reg [DEPTH];
    logic [EW-1:0]         rd_data_reg;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;

    back_state_t           state_reg;
    back_state_t           state_next;
    cmd_t                  cmd_reg;
    cmd_t                  cmd_next;
    logic [AW-1:0]         front_reg;
    logic [AW-1:0]         front_next;
    logic [CW-1:0]         held_reg;
    logic [CW-1:0]         held_next;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [MAXC_W-1:0]     target_reg;
    logic [MAXC_W-1:0]     target_next;
    logic [MAXC_W-1:0]     k_reg;
    logic [MAXC_W-1:0]     k_next;
    logic [ID_WIDTH-1:0]   pend_id_reg;
    logic [ID_WIDTH-1:0]   pend_id_next;
    logic [COST_WIDTH-1:0] pend_cost_reg;
    logic [COST_WIDTH-1:0] pend_cost_next;

    // result being formed this cycle
    logic                  emit_valid;
    logic                  emit_found;
    logic [ID_WIDTH-1:0]   emit_id;
    logic [COST_WIDTH-1:0] emit_cost;
    status_t               emit_status;
    logic [CW-1:0]         emit_count;
    logic [SUM_W-1:0]      emit_sum;
    logic                  emit_last;

    logic                   result_valid_reg;
    logic                   found_reg;
    logic [31:0]            out_task_id_reg;
    logic [31:0]            out_task_cost_reg;
    status_t                status_reg;
    logic [COUNT_OUT_W-1:0] queue_count_reg;
    logic [37:0]            cost_total_reg;
    logic                   last_reg;

    logic [ID_WIDTH-1:0]   rd_id;
    logic [COST_WIDTH-1:0] rd_cost;
    logic                  cheap;
    logic [SUM_W-1:0]      sum_take;
    logic [AW-1:0]         front_inc;
    logic [AW:0]           back_sum;
    logic [AW-1:0]         back_pos;
    logic [AW:0]           push_sum;
    logic [AW-1:0]         push_pos;
    logic [TW-1:0]         tgt_full;
    logic [TW-1:0]         tgt_half;
    logic [TW-1:0]         tgt_maxc;
    logic                  share_end;

    assign rd_id     = rd_data_reg[ID_WIDTH-1:0];
    assign rd_cost   = rd_data_reg[EW-1:ID_WIDTH];
    assign cheap     = cmd_reg.check_cost && (32'(rd_cost) < cmd_reg.min_cost);
    assign sum_take  = sum_reg - SUM_W'(rd_cost);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign share_end = (k_reg >= target_reg) || cheap;

    // circular positions: sum stays below twice the depth, one conditional subtract
    always_comb
    begin
        back_sum = (AW+1)'(front_reg) + (AW+1)'(held_reg - 1'b1);
        if (back_sum >= (AW+1)'(DEPTH))
        begin
            back_sum = back_sum - (AW+1)'(DEPTH);
        end
        back_pos = back_sum[AW-1:0];

        push_sum = (AW+1)'(front_reg) + (AW+1)'(held_reg);
        if (push_sum >= (AW+1)'(DEPTH))
        begin
            push_sum = push_sum - (AW+1)'(DEPTH);
        end
        push_pos = push_sum[AW-1:0];
    end

    // batch size: min(batch_limit, held/2), capped at MAX_RESULTS
    always_comb
    begin
        tgt_half = TW'(held_reg >> 1);
        tgt_maxc = TW'(q_cmd.batch_limit);
        tgt_full = (tgt_half < tgt_maxc) ? tgt_half : tgt_maxc;
        if (tgt_full > TW'(MAX_RESULTS))
        begin
            tgt_full = TW'(MAX_RESULTS);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        front_next     = front_reg;
        held_next      = held_reg;
        sum_next       = sum_reg;
        target_next    = target_reg;
        k_next         = k_reg;
        pend_id_next   = pend_id_reg;
        pend_cost_next = pend_cost_reg;
        q_pop          = 1'b0;
        rd_addr        = front_reg;
        wr_en          = 1'b0;
        wr_addr        = push_pos;
        wr_data        = {q_cmd.task_cost[COST_WIDTH-1:0], q_cmd.task_id[ID_WIDTH-1:0]};
        emit_valid     = 1'b0;
        emit_found     = 1'b0;
        emit_id        = '0;
        emit_cost      = '0;
        emit_status    = ST_OK;
        emit_count     = held_reg;
        emit_sum       = sum_reg;
        emit_last      = 1'b1;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    case (q_cmd.op)
                        OP_PUSH:
                        begin
                            emit_valid = 1'b1;
                            if (held_reg >= CW'(DEPTH))
                            begin
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                held_next  = held_reg + 1'b1;
                                sum_next   = sum_reg +
                                             SUM_W'(q_cmd.task_cost[COST_WIDTH-1:0]);
                                emit_count = held_next;
                                emit_sum   = sum_next;
                            end
                        end
                        OP_POP, OP_STEAL:
                        begin
                            if (held_reg == '0)
                            begin
                                emit_valid  = 1'b1;
                                emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = (q_cmd.op == OP_POP) ? back_pos : front_reg;
                                state_next = B_READ;
                            end
                        end
                        default:
                        begin
                            if (q_cmd.batch_limit == '0)
                            begin
                                emit_valid = 1'b1;
                            end
                            else if (held_reg < CW'(2))
                            begin
                                emit_valid  = 1'b1;
                                emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                target_next = MAXC_W'(tgt_full);
                                state_next  = B_READ;
                            end
                        end
                    endcase
                end
            end

            B_READ:
            begin
                emit_valid = 1'b1;
                state_next = B_IDLE;
                if ((cmd_reg.op != OP_POP) && cheap)
                begin
                    emit_status = ST_CHEAP;
                end
                else
                begin
                    held_next  = held_reg - 1'b1;
                    sum_next   = sum_take;
                    emit_found = 1'b1;
                    emit_id    = rd_id;
                    emit_cost  = rd_cost;
                    emit_count = held_next;
                    emit_sum   = sum_next;
                    if (cmd_reg.op != OP_POP)
                    begin
                        front_next = front_inc;
                    end
                    if ((cmd_reg.op == OP_SHARE) && (target_reg != MAXC_W'(1)))
                    begin
                        // hold this task until the next front cost is known
                        emit_valid     = 1'b0;
                        rd_addr        = front_inc;
                        pend_id_next   = rd_id;
                        pend_cost_next = rd_cost;
                        k_next         = MAXC_W'(1);
                        state_next     = B_SHARE;
                    end
                end
            end

            B_SHARE:
            begin
                emit_valid = 1'b1;
                emit_found = 1'b1;
                emit_id    = pend_id_reg;
                emit_cost  = pend_cost_reg;
                emit_last  = share_end;
                if (share_end)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    front_next     = front_inc;
                    held_next      = held_reg - 1'b1;
                    sum_next       = sum_take;
                    rd_addr        = front_inc;
                    pend_id_next   = rd_id;
                    pend_cost_next = rd_cost;
                    k_next         = k_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            front_reg        <= '0;
            held_reg         <= '0;
            sum_reg          <= '0;
            target_reg       <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            front_reg        <= front_next;
            held_reg         <= held_next;
            sum_reg          <= sum_next;
            target_reg       <= target_next;
            k_reg            <= k_next;
            result_valid_reg <= emit_valid;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        pend_id_reg       <= pend_id_next;
        pend_cost_reg     <= pend_cost_next;
        found_reg         <= emit_found;
        out_task_id_reg   <= 32'(emit_id);
        out_task_cost_reg <= 32'(emit_cost);
        status_reg        <= emit_status;
        queue_count_reg   <= COUNT_OUT_W'(emit_count);
        cost_total_reg    <= emit_sum;
        last_reg          <= emit_last;
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_reg[rd_addr];
    end

    assign result_valid  = result_valid_reg;
    assign found         = found_reg;
    assign out_task_id   = out_task_id_reg;
    assign out_task_cost = out_task_cost_reg;
    assign status        = status_reg;
    assign queue_count   = queue_count_reg;
    assign cost_total    = cost_total_reg;
    assign last          = last_reg;

endmodule

@@ hdl/work_stealing_task_deque_top.sv @@
// Top level of the work-stealing task deque: front-end queue plus back-end sequencer.
// A push result is registered straight from the idle state; pop and steal first pass through
// the store read state; a share batch reads the front task, then gives its tasks in turn.
// The back end retires a push per cycle while commands are queued; it takes no new command
// until a pop, steal or share batch is through, and a refused command returns from idle.
// busy is high while the two-entry command queue is full; results cannot be stalled.
// Reset (rst_n low, asynchronous) empties the deque and the queue; stored tasks are not cleared.
module work_stealing_task_deque_top
#(
    parameter int DEPTH      = 64,
    parameter int ID_WIDTH   = 32,
    parameter int COST_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] task_id,
    input  logic [31:0] task_cost,
    input  logic [5:0]  batch_limit,
    input  logic [31:0] min_cost,
    input  logic        check_cost,
    output logic        result_valid,
    output logic        found,
    output logic [31:0] out_task_id,
    output logic [31:0] out_task_cost,
    output logic [1:0]  status,
    output logic [6:0]  queue_count,
    output logic [37:0] cost_total,
    output logic        last
);
    import wstd_pkg::*;

    // command queue between front and back end
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // Front end: takes an item whenever a queue slot is free and decodes its mode.
    wstd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .task_id     (task_id),
        .task_cost   (task_cost),
        .batch_limit (batch_limit),
        .min_cost    (min_cost),
        .check_cost  (check_cost),
        .busy        (busy),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    // Back end: owns the circular task store, the occupancy and the cost total.
    // Each result is registered and strobed by result_valid for one cycle.
    wstd_back
    #(
        .DEPTH      (DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .COST_WIDTH (COST_WIDTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .found         (found),
        .out_task_id   (out_task_id),
        .out_task_cost (out_task_cost),
        .status        (status),
        .queue_count   (queue_count),
        .cost_total    (cost_total),
        .last          (last)
    );

endmodule
